/* hdl/bitmap_block_allocator_defines.svh */
// assertion macros for the bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap block allocator check failed");
// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap block allocator check failed");
`else
`define BBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

  // fixed field widths
  localparam int BLK_W  = 12;
  localparam int CFG_W  = 13;
  localparam int STAT_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    cnt_clr;
    logic    clear_wr;
    logic    rd_scan;
    logic    rd_free;
    logic    wr_alloc;
    logic    wr_free;
    logic    res_load;
    logic    res_alloc;
    status_t res_code;
    logic    push;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic req_alloc;
    logic clr_last;
    logic lim_zero;
    logic ev_valid;
    logic hit;
    logic ev_last;
    logic range_bad;
    logic bit_set;
    logic out_free;
  } bba_stat_t;

endpackage

/* hdl/bba_if.sv */
`timescale 1ns / 1ps

// request channel
interface bba_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [bba_pkg::BLK_W-1:0] block_number;

  modport source (output valid, output opcode, output block_number, input ready);
  modport sink (input valid, input opcode, input block_number, output ready);
endinterface

// result channel
interface bba_out_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::BLK_W-1:0]  allocated_block;
  logic [bba_pkg::STAT_W-1:0] status;

  modport source (output valid, output allocated_block, output status, input ready);
  modport sink (input valid, input allocated_block, input status, output ready);
endinterface

// block count register write channel
interface bba_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/bitmap_block_allocator.sv */
// First-fit block allocator over a bitmap, one bit per storage block.
// in_if carries an item with opcode (allocate or free) and block_number;
// out_if returns one item per request with allocated_block and status.
// cfg_if writes the block count; the port is always ready. The user must
// write it only while no request is in progress; the block does not enforce it.
// After reset the bitmap memory is swept to zero, one word per cycle, over all
// its words; in_if.ready stays low until the sweep is done. The block count
// resets to 4096.
// Allocate: the bitmap memory is read one word per cycle from word 0 until a
// word with a free block in range is found, or up to the last word in range
// when none is free (ST_FULL); a zero block count answers ST_FULL with no scan.
// Free: the block's word is read and its bit checked and, if set, cleared (else
// ST_ALREADY_FREE); a block out of range is answered with ST_RANGE and no read.
// One request is in progress at a time; the next is taken in the cycle after
// the result moves to the output register, so a new request is not taken
// before the last one is through. The output register holds its item while the
// receiver stalls; a new request is still accepted, and its result waits
// in a staging register until the output register is free.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_defines.svh"

module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input logic       clk,
  input logic       rst_n,
  bba_in_if.sink    in_if,
  bba_out_if.source out_if,
  bba_cfg_if.sink   cfg_if
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t st;

  // sequencer
  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  // bitmap memory, scan and result registers
  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd    (cmd),
    .st     (st)
  );

  // checks
  `BBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)
  `BBA_ASSERT_SAME(a_push_slot_free, clk, rst_n, cmd.push, st.out_free)
  `BBA_ASSERT_NEXT(a_push_shows, clk, rst_n, cmd.push, out_if.valid)
  `BBA_ASSERT_SAME(a_one_writer, clk, rst_n, 1'b1, ($onehot0({cmd.clear_wr, cmd.wr_alloc, cmd.wr_free})))
  `BBA_ASSERT_SAME(a_alloc_on_hit, clk, rst_n, cmd.wr_alloc, st.ev_valid && st.hit)

endmodule

/* hdl/bba_ctrl.sv */
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  bba_pkg::bba_stat_t st,
  output bba_pkg::bba_cmd_t  cmd
);
  import bba_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FRD   = 6'b001000,
    S_FCHK  = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing of one item
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.capture = 1'b1;
          if (st.req_alloc) begin
            if (st.lim_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_code = ST_FULL;
              state_nxt    = S_PUSH;
            end else begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_SCAN;
            end
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (st.ev_valid && st.hit) begin
          cmd.wr_alloc  = 1'b1;
          cmd.res_load  = 1'b1;
          cmd.res_alloc = 1'b1;
          cmd.res_code  = ST_OK;
          state_nxt     = S_PUSH;
        end else if (st.ev_valid && st.ev_last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FULL;
          state_nxt    = S_PUSH;
        end
      end
      S_FRD: begin
        if (st.range_bad) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_RANGE;
          state_nxt    = S_PUSH;
        end else begin
          cmd.rd_free = 1'b1;
          state_nxt   = S_FCHK;
        end
      end
      S_FCHK: begin
        cmd.res_load = 1'b1;
        if (st.bit_set) begin
          cmd.wr_free  = 1'b1;
          cmd.res_code = ST_OK;
        end else begin
          cmd.res_code = ST_ALREADY_FREE;
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (st.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

/* hdl/bba_dp.sv */
`timescale 1ns / 1ps

module bba_dp #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  bba_in_if.sink             in_if,
  bba_out_if.source          out_if,
  bba_cfg_if.sink            cfg_if,
  input  bba_pkg::bba_cmd_t  cmd,
  output bba_pkg::bba_stat_t st
);
  import bba_pkg::*;

  // word and bit index widths (word size a power of two)
  localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SH    = $clog2(WORD_BITS);
  localparam int LW    = $clog2(MAX_BLOCKS + 1);
  localparam int CW    = (LW > CFG_W) ? LW : CFG_W;

  logic [CFG_W-1:0]     total_r, total_nxt;
  logic [CW-1:0]        total_ext;
  logic [CW-1:0]        lim;
  logic [AW-1:0]        last_word;
  logic [SH-1:0]        tail_cnt;
  logic [WORD_BITS-1:0] tail_mask;

  logic [BLK_W-1:0]     blk_r;
  logic [CW-1:0]        blk_ext;
  logic [AW-1:0]        free_word;
  logic [SH-1:0]        free_off;

  logic [AW:0]          cnt_r, cnt_nxt;
  logic                 issue;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 ev_valid_r;
  logic [AW-1:0]        ev_addr_r;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;

  logic                 ev_last;
  logic [WORD_BITS-1:0] avail;
  logic [SH-1:0]        hit_idx;

  logic                 we;
  logic [AW-1:0]        wa;
  logic [WORD_BITS-1:0] wd;

  logic [BLK_W-1:0]     res_blk_r;
  status_t              res_stat_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]     out_blk_r;
  status_t              out_stat_r;

  // block count register
  assign cfg_if.ready = 1'b1;
  assign total_nxt    = cfg_if.valid ? cfg_if.data : total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= CFG_RESET;
    end else begin
      total_r <= total_nxt;
    end
  end

  // effective limit, last word in range and valid bits of that word
  assign total_ext = CW'(total_r);
  assign lim       = (total_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : total_ext;
  assign last_word = AW'((lim - CW'(1)) >> SH);
  assign tail_cnt  = lim[SH-1:0];

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      tail_mask[i] = (tail_cnt == '0) || (SH'(i) < tail_cnt);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blk_r <= in_if.block_number;
    end
  end

  assign in_if.ready = cmd.in_ready;
  assign blk_ext     = CW'(blk_r);
  assign free_word   = AW'(blk_ext >> SH);
  assign free_off    = blk_r[SH-1:0];

  // word counter shared by clearing pass and scan
  assign issue = cmd.rd_scan && (cnt_r <= {1'b0, last_word});

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.clear_wr || issue) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ev_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      ev_valid_r <= issue;
    end
  end

  // read address select
  assign rd_addr = cmd.rd_free ? free_word : cnt_r[AW-1:0];
  assign rd_en   = issue || cmd.rd_free;

  // lowest free block in the word under test
  assign ev_last = (ev_addr_r == last_word);
  assign avail   = ~rdata_r & (ev_last ? tail_mask : {WORD_BITS{1'b1}});

  always_comb begin
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        hit_idx = SH'(i);
      end
    end
  end

  // write port select
  always_comb begin
    we = 1'b0;
    wa = cnt_r[AW-1:0];
    wd = '0;
    priority if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.wr_alloc) begin
      we = 1'b1;
      wa = ev_addr_r;
      wd = rdata_r | (WORD_BITS'(1) << hit_idx);
    end else if (cmd.wr_free) begin
      we = 1'b1;
      wa = free_word;
      wd = rdata_r & ~(WORD_BITS'(1) << free_off);
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (issue) begin
      ev_addr_r <= cnt_r[AW-1:0];
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_blk_r  <= cmd.res_alloc ? BLK_W'({ev_addr_r, hit_idx}) : '0;
      res_stat_r <= cmd.res_code;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_blk_r  <= res_blk_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.allocated_block = out_blk_r;
  assign out_if.status          = out_stat_r;

  // status to controller
  assign st.in_valid  = in_if.valid;
  assign st.req_alloc = (opcode_t'(in_if.opcode) == OP_ALLOC);
  assign st.clr_last  = (cnt_r == (AW+1)'(WORDS - 1));
  assign st.lim_zero  = (lim == '0);
  assign st.ev_valid  = ev_valid_r;
  assign st.hit       = |avail;
  assign st.ev_last   = ev_last;
  assign st.range_bad = (blk_ext >= lim);
  assign st.bit_set   = rdata_r[free_off];
  assign st.out_free  = !out_valid_r || out_if.ready;

endmodule

/* dv/bitmap_block_allocator_tb.sv */
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int NUM_BLOCKS   = 4096;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 120;

  typedef struct {
    logic [BLK_W-1:0] blk;
    status_t          st;
  } alloc_result_t;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    opcode_t          op;
    logic [BLK_W-1:0] blk;
    logic [CFG_W-1:0] count;
    bit               typed;
    logic [BLK_W-1:0] exp_blk;
    status_t          exp_st;
  } directed_row_t;

  logic clk;
  logic rst_n;

  bba_in_if  in_if ();
  bba_out_if out_if ();
  bba_cfg_if cfg_if ();

  bitmap_block_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // predictor state: block usage and block count register
  bit [NUM_BLOCKS-1:0] used_map;
  logic [CFG_W-1:0]    block_count;

  alloc_result_t pending_results [$];
  alloc_result_t head_result;
  int            mismatch_count;
  int            src_idle_pct;
  int            sink_stall_pct;
  bit            hold_request;

  // walked in order after reset: extremes, zero count, saturated count, full and range cases
  directed_row_t directed_rows [27] = '{
    '{ROW_REQ, OP_FREE,  12'd0,    13'd0,    1'b1, 12'd0, ST_ALREADY_FREE},
    '{ROW_REQ, OP_ALLOC, 12'hFFF,  13'd0,    1'b1, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'd0,    13'd0,    1'b1, 12'd1, ST_OK},
    '{ROW_REQ, OP_FREE,  12'd4095, 13'd0,    1'b1, 12'd0, ST_ALREADY_FREE},
    '{ROW_REQ, OP_FREE,  12'd0,    13'd0,    1'b1, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'd5,    13'd0,    1'b1, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'hAAA,  13'd0,    1'b0, 12'd0, ST_OK},
    '{ROW_REQ, OP_FREE,  12'd1,    13'd0,    1'b1, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'h555,  13'd0,    1'b0, 12'd0, ST_OK},
    '{ROW_CFG, OP_ALLOC, 12'd0,    13'd0,    1'b0, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'd0,    13'd0,    1'b1, 12'd0, ST_FULL},
    '{ROW_REQ, OP_FREE,  12'd0,    13'd0,    1'b1, 12'd0, ST_RANGE},
    '{ROW_REQ, OP_FREE,  12'd4095, 13'd0,    1'b1, 12'd0, ST_RANGE},
    '{ROW_CFG, OP_ALLOC, 12'd0,    13'd2,    1'b0, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'd0,    13'd0,    1'b1, 12'd0, ST_FULL},
    '{ROW_REQ, OP_FREE,  12'd2,    13'd0,    1'b1, 12'd0, ST_RANGE},
    '{ROW_REQ, OP_FREE,  12'd1,    13'd0,    1'b1, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'd0,    13'd0,    1'b1, 12'd1, ST_OK},
    '{ROW_CFG, OP_ALLOC, 12'd0,    13'd1,    1'b0, 12'd0, ST_OK},
    '{ROW_REQ, OP_FREE,  12'd1,    13'd0,    1'b1, 12'd0, ST_RANGE},
    '{ROW_REQ, OP_FREE,  12'd0,    13'd0,    1'b1, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'd0,    13'd0,    1'b1, 12'd0, ST_OK},
    '{ROW_CFG, OP_ALLOC, 12'd0,    13'h1FFF, 1'b0, 12'd0, ST_OK},
    '{ROW_REQ, OP_ALLOC, 12'd0,    13'd0,    1'b0, 12'd0, ST_OK},
    '{ROW_REQ, OP_FREE,  12'd2048, 13'd0,    1'b1, 12'd0, ST_ALREADY_FREE},
    '{ROW_CFG, OP_ALLOC, 12'd0,    13'd4096, 1'b0, 12'd0, ST_OK},
    '{ROW_REQ, OP_FREE,  12'd3,    13'd0,    1'b0, 12'd0, ST_OK}
  };

  // clock and reset
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // count above the storage size saturates
  function automatic int count_limit();
    return (block_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count);
  endfunction

  // first-fit allocate or free against the predicted bitmap
  function automatic alloc_result_t apply_request(opcode_t op, logic [BLK_W-1:0] blk);
    alloc_result_t res;
    int lim;
    res.blk = '0;
    res.st  = ST_OK;
    lim = count_limit();
    if (op == OP_ALLOC) begin
      res.st = ST_FULL;
      for (int b = 0; b < lim; b++) begin
        if (!used_map[b]) begin
          used_map[b] = 1'b1;
          res.blk = BLK_W'(b);
          res.st  = ST_OK;
          break;
        end
      end
    end else if (int'(blk) >= lim) begin
      res.st = ST_RANGE;
    end else if (!used_map[blk]) begin
      res.st = ST_ALREADY_FREE;
    end else begin
      used_map[blk] = 1'b0;
    end
    return res;
  endfunction

  // random block in use below the count, or -1 when there is none
  function automatic int pick_used_block();
    int held [$];
    int lim;
    lim = count_limit();
    for (int b = 0; b < lim; b++)
      if (used_map[b]) held.push_back(b);
    if (held.size() == 0) return -1;
    return held[$urandom_range(held.size() - 1)];
  endfunction

  // offer one request and record its expected result once accepted
  task automatic offer(opcode_t op, logic [BLK_W-1:0] blk, bit typed, alloc_result_t typed_res);
    alloc_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.block_number <= blk;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = apply_request(op, blk);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // block count write once every pending result has come back
  task automatic write_count(logic [CFG_W-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    block_count = value;
  endtask

  // mostly allocates and frees of blocks in use, some double frees and wild frees
  task automatic send_random(int n_items);
    alloc_result_t none;
    int roll;
    int target;
    int lim;
    none.blk = '0;
    none.st  = ST_OK;
    for (int i = 0; i < n_items; i++) begin
      roll   = $urandom_range(99);
      lim    = count_limit();
      target = pick_used_block();
      if (roll < 50)
        offer(OP_ALLOC, BLK_W'($urandom), 1'b0, none);
      else if (roll < 80 && target >= 0)
        offer(OP_FREE, BLK_W'(target), 1'b0, none);
      else if (roll < 90 && lim > 0)
        offer(OP_FREE, BLK_W'($urandom_range(lim - 1)), 1'b0, none);
      else
        offer(OP_FREE, BLK_W'($urandom), 1'b0, none);
    end
  endtask

  // receiver: random stalls, and one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        @(posedge clk);
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected item: block %0d status %0d",
                   out_if.allocated_block, out_if.status);
      end else begin
        head_result = pending_results.pop_front();
        if (out_if.allocated_block !== head_result.blk || out_if.status !== head_result.st) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected block %0d status %0d, got block %0d status %0d",
                     head_result.blk, head_result.st, out_if.allocated_block, out_if.status);
        end
      end
    end
  end

  // stimulus
  initial begin
    alloc_result_t typed_res;
    logic [CFG_W-1:0] phase_count [10];
    int phase_len;
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_ALLOC;
    in_if.block_number = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = '0;
    used_map           = '0;
    block_count        = CFG_RESET;
    mismatch_count     = 0;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    hold_request       = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_count(directed_rows[i].count);
      end else begin
        typed_res.blk = directed_rows[i].exp_blk;
        typed_res.st  = directed_rows[i].exp_st;
        offer(directed_rows[i].op, directed_rows[i].blk, directed_rows[i].typed, typed_res);
      end
    end

    // random phases, each under its own block count and idling mix
    phase_count = '{13'd8, 13'd33, 13'd1, 13'd4096, 13'd64, 13'd8191, 13'd0,
                    CFG_W'($urandom_range(96, 2)), 13'd32,
                    CFG_W'($urandom_range(8191, 4097))};
    foreach (phase_count[p]) begin
      write_count(phase_count[p]);
      unique case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 4) hold_request = 1'b1;
      phase_len = (phase_count[p] == 0) ? 30 : PHASE_ITEMS;
      send_random(phase_len);
    end

    // drain and finish
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_if.sv
hdl/bba_ctrl.sv
hdl/bba_dp.sv
hdl/bitmap_block_allocator.sv
dv/bitmap_block_allocator_tb.sv
